[rtl/krlb_pkg.sv]
`timescale 1ns / 1ps

package krlb_pkg;

    localparam int KEY_W     = 32;
    localparam int SPACE_W   = 2;
    localparam int TAG_W     = KEY_W + SPACE_W;
    localparam int TIME_W    = 64;
    localparam int SECS_W    = 16;
    localparam int LIMIT_W   = 20;
    localparam int OUT_CNT_W = 20;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W    = SECS_W + CFG_W;

    // slot reduction for non power-of-two tables: one hex digit at a time
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = KEY_W / DIGIT_W;
    localparam int DIG_CNT_W = $clog2(DIGITS);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_NS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_UNIT_NS = 1'd1;

    localparam logic [CFG_W-1:0] WINDOW_NS_RST     = 32'd1000000000;
    localparam logic [CFG_W-1:0] BLOCK_UNIT_NS_RST = 32'd1000000000;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] expiry;
    } block_word_t;

endpackage

[rtl/keyed_rate_limiter_with_blocklist_core.sv]
`timescale 1ns / 1ps

// Keyed fixed-window rate limiter with blocklist. A beat is accepted when
// start is high and busy is low; exactly one result follows and is shown
// for a single cycle with done high. The receiver cannot stall: sample drop,
// block_written and window_count whenever done is high. With a power-of-two
// TABLE_ENTRIES an accepted beat goes through the read, look and write-back
// states and done follows the write back; a new beat can be accepted in the
// done cycle, so items are taken one at a time. Other table sizes first pass
// through a reduce state that works out the key-to-slot remainder one hex
// digit per cycle. The single read-modify-write pass over the rate and block
// memories (read, look, write back) handles one item at a time, so no two
// accesses to a slot overlap. After reset the block runs a clearing pass
// that marks every entry of both memories invalid; busy is high meanwhile.
// Configuration writes (cfg_write, cfg_index, cfg_data) are taken at any
// time and must only be done while the block is idle.

module keyed_rate_limiter_with_blocklist_core #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int COUNT_BITS    = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_write,
    input  logic [krlb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [krlb_pkg::CFG_W-1:0]        cfg_data,

    input  logic                              start,
    output logic                              busy,
    input  logic [krlb_pkg::KEY_W-1:0]        key,
    input  logic [krlb_pkg::SPACE_W-1:0]      key_space,
    input  logic [krlb_pkg::TIME_W-1:0]       now_ns,
    input  logic [krlb_pkg::SECS_W-1:0]       block_seconds,
    input  logic [krlb_pkg::LIMIT_W-1:0]      limit,
    input  logic                              verdict_after_update,

    output logic                              done,
    output logic                              drop,
    output logic                              block_written,
    output logic [krlb_pkg::OUT_CNT_W-1:0]    window_count
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int RW      = IDX_W + krlb_pkg::DIGIT_W;
    localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam int CMP_W   = (COUNT_BITS > krlb_pkg::LIMIT_W) ? COUNT_BITS : krlb_pkg::LIMIT_W;
    localparam logic [RW-1:0]         N_R       = RW'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [CMP_W-1:0]      OUT_MAX   = CMP_W'({krlb_pkg::OUT_CNT_W{1'b1}});
    localparam logic [krlb_pkg::DIG_CNT_W-1:0] LAST_DIG =
        krlb_pkg::DIG_CNT_W'(krlb_pkg::DIGITS - 1);

    typedef struct packed {
        logic                               valid;
        logic [krlb_pkg::TAG_W-1:0]         tag;
        logic [COUNT_BITS-1:0]              count;
        logic [krlb_pkg::TIME_W-1:0]        window_end;
    } rate_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_LOOK,
        ST_WB
    } state_t;

    // one remainder digit: r*16+d reduced below N by four conditional subtracts
    function automatic logic [RW-1:0] mod_step(input logic [RW-1:0] r_in);
        logic [RW-1:0] r;
        r = r_in;
        for (int k = krlb_pkg::DIGIT_W - 1; k >= 0; k--) begin
            if (r >= (N_R << k))
            begin
                r = r - (N_R << k);
            end
        end
        return r;
    endfunction

    // control
    state_t                             state_reg, state_next;
    logic [IDX_W-1:0]                   clr_idx_reg;
    logic [krlb_pkg::DIG_CNT_W-1:0]     dig_cnt_reg;
    logic [krlb_pkg::CFG_W-1:0]         window_ns_reg;
    logic [krlb_pkg::CFG_W-1:0]         block_unit_ns_reg;
    logic                               done_reg;

    // item payload
    logic [krlb_pkg::TAG_W-1:0]         tag_reg;
    logic [krlb_pkg::TIME_W-1:0]        now_reg;
    logic [krlb_pkg::PROD_W-1:0]        prod_reg;
    logic [krlb_pkg::LIMIT_W-1:0]       limit_reg;
    logic                               after_reg;
    logic [IDX_W-1:0]                   slot_reg;
    logic [krlb_pkg::KEY_W-1:0]         digits_reg;

    // look stage results
    logic                               hit_reg;
    logic [COUNT_BITS-1:0]              cnt_reg;
    logic [krlb_pkg::TIME_W-1:0]        win_end_reg;
    logic [krlb_pkg::TIME_W-1:0]        exp_reg;
    logic                               found_reg;
    logic                               old_lt_reg;

    // result
    logic                               drop_reg;
    logic                               written_reg;
    logic [krlb_pkg::OUT_CNT_W-1:0]     count_out_reg;

    // memories
    rate_word_t                         rate_mem [TABLE_ENTRIES];
    krlb_pkg::block_word_t              block_mem [TABLE_ENTRIES];
    rate_word_t                         rate_q_reg;
    krlb_pkg::block_word_t              block_q_reg;

    logic                               accept;
    logic [RW-1:0]                      step_out;
    logic                               rate_hit;
    logic [COUNT_BITS-1:0]              cnt_look;
    logic [krlb_pkg::TIME_W:0]          win_sum;
    logic [krlb_pkg::TIME_W:0]          exp_sum;
    logic                               blk_found;
    logic                               written;
    logic [CMP_W-1:0]                   cnt_ext;
    logic                               rate_we;
    logic                               block_we;
    logic [IDX_W-1:0]                   waddr;
    rate_word_t                         rate_wdata;
    krlb_pkg::block_word_t              block_wdata;

    assign accept = (state_reg == ST_IDLE) && start;
    assign busy   = (state_reg != ST_IDLE);

    assign step_out = mod_step({slot_reg,
        digits_reg[krlb_pkg::KEY_W-1 -: krlb_pkg::DIGIT_W]});

    // look: rate hit needs matching tag and an unexpired window
    always_comb
    begin
        rate_hit = rate_q_reg.valid && (rate_q_reg.tag == tag_reg)
                   && (rate_q_reg.window_end > now_reg);
        if (!rate_hit)
        begin
            cnt_look = COUNT_BITS'(1);
        end
        else if (rate_q_reg.count == COUNT_MAX)
        begin
            cnt_look = rate_q_reg.count;
        end
        else
        begin
            cnt_look = rate_q_reg.count + COUNT_BITS'(1);
        end
        win_sum   = {1'b0, now_reg} + (krlb_pkg::TIME_W + 1)'(window_ns_reg);
        exp_sum   = {1'b0, now_reg} + (krlb_pkg::TIME_W + 1)'(prod_reg);
        blk_found = block_q_reg.valid && (block_q_reg.tag == tag_reg);
    end

    // write back: limit check and memory writes
    always_comb
    begin
        cnt_ext = CMP_W'(cnt_reg);
        written = hit_reg && (limit_reg != '0) && (cnt_ext > CMP_W'(limit_reg));

        waddr       = (state_reg == ST_CLEAR) ? clr_idx_reg : slot_reg;
        rate_we     = (state_reg == ST_CLEAR) || (state_reg == ST_WB);
        rate_wdata  = '0;
        block_wdata = '0;
        block_we    = (state_reg == ST_CLEAR);
        if (state_reg == ST_WB)
        begin
            rate_wdata.valid      = 1'b1;
            rate_wdata.tag        = tag_reg;
            rate_wdata.count      = cnt_reg;
            rate_wdata.window_end = win_end_reg;
            if (written)
            begin
                block_we           = 1'b1;
                block_wdata.valid  = 1'b1;
                block_wdata.tag    = tag_reg;
                block_wdata.expiry = exp_reg;
            end
            else if (found_reg && old_lt_reg)
            begin
                // stale block entry: report the drop, then retire it
                block_we    = 1'b1;
                block_wdata = block_q_reg;
                block_wdata.valid = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = IS_POW2 ? ST_READ : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (dig_cnt_reg == LAST_DIG)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_WB;
            ST_WB:    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_idx_reg       <= '0;
            dig_cnt_reg       <= '0;
            window_ns_reg     <= krlb_pkg::WINDOW_NS_RST;
            block_unit_ns_reg <= krlb_pkg::BLOCK_UNIT_NS_RST;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_WB);
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (accept)
            begin
                dig_cnt_reg <= '0;
            end
            else if (state_reg == ST_REDUCE)
            begin
                dig_cnt_reg <= dig_cnt_reg + krlb_pkg::DIG_CNT_W'(1);
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    krlb_pkg::REG_WINDOW_NS:     window_ns_reg     <= cfg_data;
                    krlb_pkg::REG_BLOCK_UNIT_NS: block_unit_ns_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag_reg    <= {key_space, key};
            now_reg    <= now_ns;
            prod_reg   <= krlb_pkg::PROD_W'(block_seconds)
                          * krlb_pkg::PROD_W'(block_unit_ns_reg);
            limit_reg  <= limit;
            after_reg  <= verdict_after_update;
            digits_reg <= key;
            slot_reg   <= IS_POW2 ? key[IDX_W-1:0] : '0;
        end
        else if (state_reg == ST_REDUCE)
        begin
            slot_reg   <= step_out[IDX_W-1:0];
            digits_reg <= digits_reg << krlb_pkg::DIGIT_W;
        end

        if (state_reg == ST_LOOK)
        begin
            hit_reg     <= rate_hit;
            cnt_reg     <= cnt_look;
            // a hit keeps its window; a miss opens one, saturating at the top
            if (rate_hit)
            begin
                win_end_reg <= rate_q_reg.window_end;
            end
            else
            begin
                win_end_reg <= win_sum[krlb_pkg::TIME_W] ? '1 : win_sum[krlb_pkg::TIME_W-1:0];
            end
            exp_reg    <= exp_sum[krlb_pkg::TIME_W] ? '1 : exp_sum[krlb_pkg::TIME_W-1:0];
            found_reg  <= blk_found;
            old_lt_reg <= block_q_reg.expiry < now_reg;
        end

        if (state_reg == ST_WB)
        begin
            drop_reg      <= after_reg ? (written || found_reg) : found_reg;
            written_reg   <= written;
            count_out_reg <= (cnt_ext > OUT_MAX) ? '1 : cnt_ext[krlb_pkg::OUT_CNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rate_we)
        begin
            rate_mem[waddr] <= rate_wdata;
        end
        rate_q_reg <= rate_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (block_we)
        begin
            block_mem[waddr] <= block_wdata;
        end
        block_q_reg <= block_mem[slot_reg];
    end

    assign done          = done_reg;
    assign drop          = drop_reg;
    assign block_written = written_reg;
    assign window_count  = count_out_reg;

endmodule

[tb/tb_keyed_rate_limiter_with_blocklist_core.sv]
`timescale 1ns / 1ps

module tb_keyed_rate_limiter_with_blocklist_core;

    // Flow: the initial block fills event_q with packet beats and register
    // writes. The driver below launches them one at a time. At each accepting
    // edge the predictor runs the beat against its own copy of both tables and
    // pushes one verdict into verdict_q. The monitor compares every done beat
    // with the oldest queued verdict.

    import krlb_pkg::*;

    localparam int TABLE_ENTRIES = 1024;
    localparam int COUNT_BITS    = 20;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TIME_W-1:0]     TIME_MAX  = '1;

    typedef enum logic {EV_PACKET, EV_SET_REG} ev_kind_t;

    // One entry of the stimulus stream: either a packet beat or a register write.
    typedef struct {
        ev_kind_t              kind;
        logic [KEY_W-1:0]      key;
        logic [SPACE_W-1:0]    key_space;
        logic [TIME_W-1:0]     now_ns;
        logic [SECS_W-1:0]     secs;
        logic [LIMIT_W-1:0]    lim;
        logic                  after;
        int                    gap;      // idle cycles before this beat
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]      reg_val;
    } pkt_event_t;

    typedef struct {
        logic                  drop;
        logic                  wrote;
        logic [OUT_CNT_W-1:0]  count;
    } verdict_t;

    // DUT signals. Every input starts at a known value.
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [KEY_W-1:0]      key = '0;
    logic [SPACE_W-1:0]    key_space = '0;
    logic [TIME_W-1:0]     now_ns = '0;
    logic [SECS_W-1:0]     block_seconds = '0;
    logic [LIMIT_W-1:0]    limit = '0;
    logic                  verdict_after_update = 1'b0;
    logic                  done;
    logic                  drop;
    logic                  block_written;
    logic [OUT_CNT_W-1:0]  window_count;

    pkt_event_t  event_q[$];
    verdict_t    verdict_q[$];
    pkt_event_t  cur_pkt;       // beat currently offered on the ports
    int          hold_cnt;      // idle cycles spent before the head beat
    int          idle_run;      // consecutive edges with nothing in flight
    int          fail_cnt;
    int          beats_seen;
    int          drops_seen;
    int          blocks_seen;
    int          reg_writes;
    logic [TIME_W-1:0] stim_now;

    // Predictor copy of the configuration and of both tables.
    logic [CFG_W-1:0]      pred_window;
    logic [CFG_W-1:0]      pred_unit;
    logic                  rt_valid  [TABLE_ENTRIES];
    logic [TAG_W-1:0]      rt_tag    [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] rt_count  [TABLE_ENTRIES];
    logic [TIME_W-1:0]     rt_end    [TABLE_ENTRIES];
    logic                  bl_valid  [TABLE_ENTRIES];
    logic [TAG_W-1:0]      bl_tag    [TABLE_ENTRIES];
    logic [TIME_W-1:0]     bl_expiry [TABLE_ENTRIES];

    keyed_rate_limiter_with_blocklist_core #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .start                (start),
        .busy                 (busy),
        .key                  (key),
        .key_space            (key_space),
        .now_ns               (now_ns),
        .block_seconds        (block_seconds),
        .limit                (limit),
        .verdict_after_update (verdict_after_update),
        .done                 (done),
        .drop                 (drop),
        .block_written        (block_written),
        .window_count         (window_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Window ends and block expiries clamp at the top of the 64-bit time range.
    function automatic logic [TIME_W-1:0] add_sat64(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    // Runs one accepted beat through the predictor tables and queues its verdict.
    task automatic limiter_predict(input pkt_event_t ev);
        logic [TAG_W-1:0]      tg;
        int unsigned           sl;
        logic                  hit;
        logic [TIME_W-1:0]     hit_exp;
        logic                  wrote;
        logic [COUNT_BITS-1:0] cnt;
        logic [PROD_W-1:0]     dur;
        verdict_t              v;
        tg      = {ev.key_space, ev.key};
        sl      = ev.key % TABLE_ENTRIES;
        hit     = 1'b0;
        hit_exp = '0;
        wrote   = 1'b0;
        // verdict before counting sees the table as it was
        if (!ev.after && bl_valid[sl] && bl_tag[sl] == tg)
        begin
            hit     = 1'b1;
            hit_exp = bl_expiry[sl];
        end
        // miss, collision or expired window: start a fresh window
        if (!rt_valid[sl] || rt_tag[sl] != tg || rt_end[sl] <= ev.now_ns)
        begin
            cnt          = COUNT_BITS'(1);
            rt_valid[sl] = 1'b1;
            rt_tag[sl]   = tg;
            rt_end[sl]   = add_sat64(ev.now_ns, TIME_W'(pred_window));
        end
        else
        begin
            cnt = rt_count[sl];
            if (cnt != COUNT_MAX)
                cnt++;
            if (ev.lim != 0 && cnt > ev.lim)
            begin
                wrote         = 1'b1;
                dur           = ev.secs * pred_unit;
                bl_valid[sl]  = 1'b1;
                bl_tag[sl]    = tg;
                bl_expiry[sl] = add_sat64(ev.now_ns, TIME_W'(dur));
            end
        end
        rt_count[sl] = cnt;
        if (ev.after && bl_valid[sl] && bl_tag[sl] == tg)
        begin
            hit     = 1'b1;
            hit_exp = bl_expiry[sl];
        end
        // stale entry is cleared on lookup, unless this beat just rewrote it
        if (hit && !wrote && hit_exp < ev.now_ns)
            bl_valid[sl] = 1'b0;
        v.drop  = hit;
        v.wrote = wrote;
        v.count = OUT_CNT_W'(cnt);
        verdict_q.push_back(v);
    endtask

    task automatic add_pkt(input logic [KEY_W-1:0] k, input logic [SPACE_W-1:0] sp,
                           input logic [TIME_W-1:0] t, input logic [SECS_W-1:0] secs,
                           input logic [LIMIT_W-1:0] lim, input logic after,
                           input int gap);
        pkt_event_t ev;
        ev           = '{kind: EV_PACKET, default: '0};
        ev.kind      = EV_PACKET;
        ev.key       = k;
        ev.key_space = sp;
        ev.now_ns    = t;
        ev.secs      = secs;
        ev.lim       = lim;
        ev.after     = after;
        ev.gap       = gap;
        event_q.push_back(ev);
    endtask

    task automatic add_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] val);
        pkt_event_t ev;
        ev         = '{kind: EV_SET_REG, default: '0};
        ev.kind    = EV_SET_REG;
        ev.reg_idx = idx;
        ev.reg_val = val;
        event_q.push_back(ev);
    endtask

    // Random traffic over a small pool of keys. Pool keys come in groups of
    // three sharing a slot; the third of each group is the second's key in
    // another key space. Sticky key choice builds counts past the limits.
    task automatic random_phase(input int n, input int unsigned step_max,
                                input bit gaps_on);
        logic [KEY_W-1:0]   pool_key   [12];
        logic [SPACE_W-1:0] pool_space [12];
        logic [9:0]         slot_bits;
        logic [KEY_W-1:0]   k;
        logic [SPACE_W-1:0] sp;
        logic [SECS_W-1:0]  secs;
        logic [LIMIT_W-1:0] lim;
        int                 gap;
        int                 p;
        int                 r;
        p = 0;
        slot_bits = '0;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 3 == 0)
                slot_bits = 10'($urandom());
            if (i % 3 == 2)
            begin
                pool_key[i]   = pool_key[i-1];
                pool_space[i] = pool_space[i-1] ^ 2'b01;
            end
            else
            begin
                pool_key[i]   = {22'($urandom()), slot_bits};
                pool_space[i] = 2'($urandom_range(0, 3));
            end
        end
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                if ($urandom_range(0, 99) >= 60)
                    p = $urandom_range(0, 11);
                k  = pool_key[p];
                sp = pool_space[p];
            end
            else
            begin
                // noise: any key in any space
                k  = $urandom();
                sp = 2'($urandom_range(0, 3));
            end
            r = $urandom_range(0, 99);
            if (r < 10)
                lim = '0;
            else if (r < 15)
                lim = LIMIT_W'($urandom_range(0, 20'hFFFFF));
            else
                lim = LIMIT_W'($urandom_range(1, 6));
            if ($urandom_range(0, 99) < 85)
                secs = SECS_W'($urandom_range(0, 20));
            else
                secs = SECS_W'($urandom_range(0, 16'hFFFF));
            r = $urandom_range(0, 99);
            if (r < 3)
                stim_now = {$urandom(), $urandom()};
            else if (r < 5)
                stim_now = TIME_MAX - TIME_W'($urandom_range(0, 5000));
            else
                stim_now = stim_now + TIME_W'($urandom_range(0, step_max));
            // idle bursts, with every third stretch of 32 beats left dense
            gap = 0;
            if (gaps_on && (i / 32) % 3 != 2 && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 15);
            add_pkt(k, sp, stim_now, secs, lim, 1'($urandom_range(0, 1)), gap);
        end
    endtask

    // Driver: offers the head of event_q. A packet beat stays on the ports
    // until an edge with start high and busy low; the predictor runs at that
    // same edge. Register writes wait until nothing is in flight.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic       send_n;
        logic       wr_n;
        pkt_event_t ev;
        if (!rst_n)
        begin
            start                <= 1'b0;
            cfg_write            <= 1'b0;
            cfg_index            <= '0;
            cfg_data             <= '0;
            key                  <= '0;
            key_space            <= '0;
            now_ns               <= '0;
            block_seconds        <= '0;
            limit                <= '0;
            verdict_after_update <= 1'b0;
            hold_cnt = 0;
            idle_run = 0;
        end
        else
        begin
            send_n = start;
            wr_n   = 1'b0;
            if (start && !busy)
            begin
                limiter_predict(cur_pkt);
                send_n = 1'b0;
            end
            // quiet edges in a row keep this clear of the monitor's pop
            if (verdict_q.size() == 0 && !busy && !start && !cfg_write)
                idle_run++;
            else
                idle_run = 0;
            if (!send_n && event_q.size() != 0)
            begin
                ev = event_q[0];
                if (ev.kind == EV_SET_REG)
                begin
                    if (idle_run >= 2)
                    begin
                        wr_n = 1'b1;
                        cfg_index <= ev.reg_idx;
                        cfg_data  <= ev.reg_val;
                        if (ev.reg_idx == REG_WINDOW_NS)
                            pred_window = ev.reg_val;
                        else if (ev.reg_idx == REG_BLOCK_UNIT_NS)
                            pred_unit = ev.reg_val;
                        reg_writes++;
                        void'(event_q.pop_front());
                        idle_run = 0;
                    end
                end
                else if (hold_cnt < ev.gap)
                begin
                    hold_cnt++;
                end
                else
                begin
                    hold_cnt = 0;
                    cur_pkt  = ev;
                    send_n   = 1'b1;
                    key                  <= ev.key;
                    key_space            <= ev.key_space;
                    now_ns               <= ev.now_ns;
                    block_seconds        <= ev.secs;
                    limit                <= ev.lim;
                    verdict_after_update <= ev.after;
                    void'(event_q.pop_front());
                end
            end
            start     <= send_n;
            cfg_write <= wr_n;
        end
    end

    // Monitor: a result is taken from the ports only in the done cycle.
    always @(posedge clk)
    begin : monitor
        verdict_t exp_v;
        if (rst_n && done)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result beat with no verdict pending");
                fail_cnt++;
            end
            else
            begin
                exp_v = verdict_q.pop_front();
                beats_seen++;
                if (drop)
                    drops_seen++;
                if (block_written)
                    blocks_seen++;
                if (drop !== exp_v.drop)
                begin
                    $error("drop: expected %0d, got %0d", exp_v.drop, drop);
                    fail_cnt++;
                end
                if (block_written !== exp_v.wrote)
                begin
                    $error("block_written: expected %0d, got %0d", exp_v.wrote, block_written);
                    fail_cnt++;
                end
                if (window_count !== exp_v.count)
                begin
                    $error("window_count: expected %0d, got %0d", exp_v.count, window_count);
                    fail_cnt++;
                end
            end
        end
    end

    // Hang guard, far beyond the slowest legal run including the clearing pass.
    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        fail_cnt    = 0;
        beats_seen  = 0;
        drops_seen  = 0;
        blocks_seen = 0;
        reg_writes  = 0;
        pred_window = WINDOW_NS_RST;
        pred_unit   = BLOCK_UNIT_NS_RST;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            rt_valid[i] = 1'b0;
            bl_valid[i] = 1'b0;
        end

        // Directed beats under the reset configuration (1 s window and unit).
        // args: key, space, now, block_seconds, limit, verdict_after, gap
        add_pkt(32'h0, 2'd0, 64'd0, 16'd0, 20'd0, 1'b0, 0);
        // all-ones fields, key space three, window end clamps at max time
        add_pkt(32'hFFFF_FFFF, 2'd3, TIME_MAX - 10, 16'hFFFF, 20'hFFFFF, 1'b1, 0);
        add_pkt(32'hFFFF_FFFF, 2'd3, TIME_MAX - 5, 16'hFFFF, 20'hFFFFF, 1'b1, 0);
        // limit of one: second beat blocks with zero duration (expiry = now)
        add_pkt(32'd5, 2'd1, 64'd1000, 16'd0, 20'd1, 1'b0, 0);
        add_pkt(32'd5, 2'd1, 64'd1001, 16'd0, 20'd1, 1'b0, 0);
        // stale block found before counting, but the new block wins
        add_pkt(32'd5, 2'd1, 64'd1002, 16'd2, 20'd1, 1'b0, 3);
        // unlimited, verdict after counting still sees the live block
        add_pkt(32'd5, 2'd1, 64'd1003, 16'd0, 20'd0, 1'b1, 0);
        // same slot, other key; then same key in another space
        add_pkt(32'd1029, 2'd1, 64'd1004, 16'd0, 20'd1, 1'b0, 0);
        add_pkt(32'd5, 2'd2, 64'd1004, 16'd0, 20'd1, 1'b1, 1);
        // rate entry was evicted, block entry survives
        add_pkt(32'd5, 2'd1, 64'd1005, 16'd0, 20'd0, 1'b0, 0);
        // window expired and block expired: dropped once, then cleared
        add_pkt(32'd5, 2'd1, 64'd3_000_000_000, 16'd0, 20'd0, 1'b1, 0);
        add_pkt(32'd5, 2'd1, 64'd3_000_000_001, 16'd0, 20'd0, 1'b1, 0);
        // block expiry clamps at max time
        add_pkt(32'd77, 2'd0, TIME_MAX - 100, 16'hFFFF, 20'd1, 1'b0, 0);
        add_pkt(32'd77, 2'd0, TIME_MAX - 99, 16'hFFFF, 20'd1, 1'b1, 0);
        add_pkt(32'd77, 2'd0, TIME_MAX, 16'hFFFF, 20'd1, 1'b0, 2);
        // expiry equal to now is kept; later lookup clears it
        add_pkt(32'd300, 2'd0, 64'd10, 16'd0, 20'd1, 1'b0, 0);
        add_pkt(32'd300, 2'd0, 64'd11, 16'd0, 20'd1, 1'b1, 0);
        add_pkt(32'd300, 2'd0, 64'd11, 16'd0, 20'd0, 1'b0, 0);
        add_pkt(32'd300, 2'd0, 64'd20, 16'd0, 20'd0, 1'b0, 5);
        add_pkt(32'd300, 2'd0, 64'd21, 16'd0, 20'd0, 1'b0, 0);
        // limit at its top: never exceeded
        add_pkt(32'd300, 2'd0, 64'd22, 16'hA5A5, 20'hFFFFF, 1'b1, 0);

        stim_now = 64'd50_000;
        // short windows against modest time steps
        add_reg_write(REG_WINDOW_NS, 32'd100);
        add_reg_write(REG_BLOCK_UNIT_NS, 32'd7);
        random_phase(350, 30, 1'b1);
        // smallest nonzero settings
        add_reg_write(REG_WINDOW_NS, 32'd1);
        add_reg_write(REG_BLOCK_UNIT_NS, 32'd1);
        random_phase(250, 2, 1'b1);
        // zero window and zero block unit
        add_reg_write(REG_WINDOW_NS, 32'd0);
        add_reg_write(REG_BLOCK_UNIT_NS, 32'd0);
        random_phase(200, 3, 1'b1);
        // all-ones settings: long windows, clamped expiries
        add_reg_write(REG_WINDOW_NS, 32'hFFFF_FFFF);
        add_reg_write(REG_BLOCK_UNIT_NS, 32'hFFFF_FFFF);
        random_phase(250, 1_000_000, 1'b1);
        add_reg_write(REG_WINDOW_NS, 32'd5000);
        add_reg_write(REG_BLOCK_UNIT_NS, 32'd1000);
        random_phase(350, 800, 1'b1);
        // closing stretch back to back
        random_phase(150, 800, 1'b0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (event_q.size() != 0 || start || verdict_q.size() != 0)
            @(posedge clk);
        // room for any stray result beat to show up
        repeat (40) @(posedge clk);

        $display("Covered %0d events across %0d register writes and the reset settings.",
                 beats_seen, reg_writes);
        $display("Dropped %0d, block entries written %0d.", drops_seen, blocks_seen);
        if (fail_cnt == 0 && verdict_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
